FILE: hw/rtl/feal4_block_encrypt_defines.svh
// ----------------------------------------------------------------------------
// FEAL-4 block encryptor assertion macros
// Concurrent check wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FEAL4_BLOCK_ENCRYPT_DEFINES_SVH
`define FEAL4_BLOCK_ENCRYPT_DEFINES_SVH

`ifndef SYNTH
// Condition must hold at every clock edge outside reset
`define FEAL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("feal4 check failed");
// Antecedent in one cycle implies consequent in the next
`define FEAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("feal4 check failed");
`else
`define FEAL_ASSERT_ALWAYS(label, cond)
`define FEAL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/feal4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEAL-4 package
// Widths, key register indexes and the G / F mixing functions.
// ----------------------------------------------------------------------------
package feal4_pkg;

    localparam int WORD_W    = 32;
    localparam int BLOCK_W   = 2 * WORD_W;
    localparam int NUM_KEYS  = 6;
    localparam int KEY_IDX_W = 3;
    localparam int NUM_RND   = 4;

    // Configuration register indexes
    localparam logic [KEY_IDX_W-1:0] KEY_ROUND_0    = 3'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_ROUND_1    = 3'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_ROUND_2    = 3'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_ROUND_3    = 3'd3;
    localparam logic [KEY_IDX_W-1:0] KEY_WHITEN_LOW = 3'd4;
    localparam logic [KEY_IDX_W-1:0] KEY_WHITEN_HI  = 3'd5;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [7:0]        t_byte;

    // G: rotate-left-3 of (a + b + m) mod 256
    function automatic t_byte g_mix(input t_byte a, input t_byte b, input logic m);
        t_byte s;
        s = a + b + {7'd0, m};
        return {s[4:0], s[7:5]};
    endfunction

    // F: bytes taken little-endian, y0 packed into the top byte
    function automatic t_word f_mix(input t_word w);
        t_byte t;
        t_byte y0;
        t_byte y1;
        t_byte y2;
        t_byte y3;
        t  = w[23:16] ^ w[31:24];
        y1 = g_mix(w[7:0] ^ w[15:8], t, 1'b1);
        y0 = g_mix(w[7:0], y1, 1'b0);
        y2 = g_mix(t, y1, 1'b0);
        y3 = g_mix(w[31:24], y2, 1'b1);
        return {y0, y1, y2, y3};
    endfunction

endpackage

FILE: hw/rtl/feal4_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEAL-4 round stage
// One Feistel round as a registered pipeline stage with valid/ready:
// (left, right) -> (right, left ^ F(right ^ key)).
// ----------------------------------------------------------------------------
module feal4_round
    import feal4_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_word i_left,
    input  t_word i_right,
    input  t_word i_key,
    output logic  o_valid,
    input  logic  i_ready,
    output t_word o_left,
    output t_word o_right
);

    logic  r_valid;
    t_word r_left;
    t_word r_right;
    t_word n_left;
    t_word n_right;

    // Stage takes a beat when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    // Round function
    always_comb begin
        n_left  = i_right;
        n_right = i_left ^ f_mix(i_right ^ i_key);
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

FILE: hw/rtl/feal4_block_encrypt.sv
`timescale 1ns / 1ps
// An input beat passes one whitening stage, then one register stage per Feistel
// round. Throughput: one 64-bit block per cycle while the output accepts; each
// stage holds one block and moves on whenever the next stage is free, so
// bubbles are squeezed out.
// Reset (synchronous, active low) empties the pipeline and clears all keys.
// ----------------------------------------------------------------------------
// FEAL-4 block encryptor
// Whitening stage plus four round stages; keys written over a plain port.
// ----------------------------------------------------------------------------
`include "feal4_block_encrypt_defines.svh"

module feal4_block_encrypt
    import feal4_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [KEY_IDX_W-1:0] i_cfg_addr,
    input  logic [WORD_W-1:0]    i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BLOCK_W-1:0]   s_axis_tdata,  // [63:0] plaintext
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BLOCK_W-1:0]   m_axis_tdata   // [63:0] ciphertext
);

    t_word r_key [NUM_KEYS];

    // Key registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                KEY_ROUND_0:    r_key[KEY_ROUND_0]    <= i_cfg_data;
                KEY_ROUND_1:    r_key[KEY_ROUND_1]    <= i_cfg_data;
                KEY_ROUND_2:    r_key[KEY_ROUND_2]    <= i_cfg_data;
                KEY_ROUND_3:    r_key[KEY_ROUND_3]    <= i_cfg_data;
                KEY_WHITEN_LOW: r_key[KEY_WHITEN_LOW] <= i_cfg_data;
                KEY_WHITEN_HI:  r_key[KEY_WHITEN_HI]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valids: index 0 is whitening, 1..4 the rounds
    // Stage readies: index g feeds round g, the last one is the output
    logic [NUM_RND:0]   stg_valid;
    logic [NUM_RND+1:1] stg_ready;
    t_word              stg_left  [NUM_RND+1];
    t_word              stg_right [NUM_RND+1];

    // Whitening stage: left = lo ^ kl, right = left ^ (hi ^ kh)
    logic  r_wh_valid;
    t_word r_wh_left;
    t_word r_wh_right;
    t_word n_wh_left;
    t_word n_wh_right;

    assign s_axis_tready = !r_wh_valid || stg_ready[1];

    always_comb begin
        n_wh_left  = s_axis_tdata[WORD_W-1:0] ^ r_key[KEY_WHITEN_LOW];
        n_wh_right = n_wh_left ^ s_axis_tdata[BLOCK_W-1:WORD_W] ^ r_key[KEY_WHITEN_HI];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wh_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_wh_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_wh_left  <= n_wh_left;
            r_wh_right <= n_wh_right;
        end
    end

    assign stg_valid[0]         = r_wh_valid;
    assign stg_left[0]          = r_wh_left;
    assign stg_right[0]         = r_wh_right;
    assign stg_ready[NUM_RND+1] = m_axis_tready;

    // Round stages
    for (genvar g = 0; g < NUM_RND; g++) begin : g_round
        feal4_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g+1]),
            .i_left  (stg_left[g]),
            .i_right (stg_right[g]),
            .i_key   (r_key[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+2]),
            .o_left  (stg_left[g+1]),
            .o_right (stg_right[g+1])
        );
    end

    // Final XOR: ciphertext = {cl ^ d, cl}
    assign m_axis_tvalid = stg_valid[NUM_RND];
    assign m_axis_tdata  = {stg_right[NUM_RND] ^ stg_left[NUM_RND], stg_right[NUM_RND]};

    // Input is back-pressured only when every stage holds a block
    `FEAL_ASSERT_ALWAYS(a_full_when_blocked, s_axis_tready || (&stg_valid))
    // Pipeline is empty on the first cycle after reset
    `FEAL_ASSERT_ALWAYS(a_empty_after_reset, $past(i_rst_n) || (stg_valid == '0))
    // A block leaving the first round stage lands in the second
    `FEAL_ASSERT_NEXT(a_round_advance, stg_valid[1] && stg_ready[2], stg_valid[2])
    // An accepted input beat always occupies the whitening stage next cycle
    `FEAL_ASSERT_NEXT(a_input_lands, s_axis_tvalid && s_axis_tready, stg_valid[0])

endmodule
